// ----- rtl/assert_macros.svh -----
// assertion macros shared by the filter rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// cond holds -> prop holds in the same cycle
`define CHK_IMPLIES(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("implication check failed");

// cond holds -> prop holds in the next cycle
`define CHK_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("next-cycle check failed");

`else

`define CHK_IMPLIES(label, clk, rst, cond, prop)
`define CHK_NEXT(label, clk, rst, cond, prop)

`endif

`endif

// ----- rtl/tmaf_pkg.sv -----
// package: widths, command codes and control structs of the trimmed mean filter
`timescale 1ns / 1ps

package tmaf_pkg;

  localparam int SAMPLE_W = 12;
  localparam int CH_W     = 4;
  localparam int CMD_W    = 2;

  localparam int CHANNELS_DEF = 4;
  localparam int DEPTH_DEF    = 12;

  localparam logic [CMD_W-1:0] CMD_STORE    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ_ONE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ_ALL = 2'd2;

  // start value of the running minimum
  localparam logic [SAMPLE_W-1:0] LO_INIT = {SAMPLE_W{1'b1}};

  typedef struct packed {
    logic clear;
    logic take;
    logic div_start;
  } calc_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } calc_stat_t;

endpackage

// ----- rtl/tmaf_req_if.sv -----
// request channel: command, sample and channel number
`timescale 1ns / 1ps

interface tmaf_req_if;
  import tmaf_pkg::*;

  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [SAMPLE_W-1:0] sample;
  logic [CH_W-1:0]     channel;

  modport source (output valid, command, sample, channel, input ready);
  modport sink   (input valid, command, sample, channel, output ready);
endinterface

// ----- rtl/tmaf_rsp_if.sv -----
// response channel: one filtered channel value per item
`timescale 1ns / 1ps

interface tmaf_rsp_if;
  import tmaf_pkg::*;

  logic                valid;
  logic                ready;
  logic [CH_W-1:0]     channel_index;
  logic [SAMPLE_W-1:0] filtered_value;
  logic                channel_ok;
  logic                last;

  modport source (output valid, channel_index, filtered_value, channel_ok, last,
                  input ready);
  modport sink   (input valid, channel_index, filtered_value, channel_ok, last,
                  output ready);
endinterface

// ----- rtl/tmaf_mem.sv -----
// sample store: one write port, one registered read port
`timescale 1ns / 1ps

module tmaf_mem #(
  parameter int WORDS = tmaf_pkg::CHANNELS_DEF * tmaf_pkg::DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [$clog2(WORDS)-1:0]      waddr,
  input  logic [tmaf_pkg::SAMPLE_W-1:0] wdata,
  input  logic                          re,
  input  logic [$clog2(WORDS)-1:0]      raddr,
  output logic [tmaf_pkg::SAMPLE_W-1:0] rdata
);
  import tmaf_pkg::*;

  logic [SAMPLE_W-1:0] mem [WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/tmaf_calc.sv -----
// shared unit: running sum, max and min, then (sum - max - min) times a reciprocal 1/(DEPTH-2)
`timescale 1ns / 1ps

module tmaf_calc #(
  parameter int DEPTH = tmaf_pkg::DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  tmaf_pkg::calc_ctrl_t          ctrl,
  input  logic [tmaf_pkg::SAMPLE_W-1:0] data,
  output tmaf_pkg::calc_stat_t          stat,
  output logic [tmaf_pkg::SAMPLE_W-1:0] quot
);
  import tmaf_pkg::*;

  localparam int SUM_W   = SAMPLE_W + $clog2(DEPTH);
  localparam int DIVISOR = DEPTH - 2;
  localparam int SHIFT   = SUM_W + $clog2(DIVISOR);
  localparam int RECIP_W = SUM_W + 2;
  localparam int PROD_W  = SUM_W + RECIP_W;
  // ceil(2^SHIFT / DIVISOR) gives the exact floor quotient for any dividend below 2^SUM_W
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

  logic [SUM_W-1:0]    sum;
  logic [SAMPLE_W-1:0] hi;
  logic [SAMPLE_W-1:0] lo;
  logic [SUM_W-1:0]    num;
  logic [PROD_W-1:0]   prod;
  logic                busy;
  logic                done;

  assign prod = PROD_W'(num) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctrl.clear) begin
        sum <= '0;
        hi  <= '0;
        lo  <= LO_INIT;
      end else if (ctrl.take) begin
        sum <= sum + SUM_W'(data);
        if (data > hi) begin
          hi <= data;
        end
        if (data < lo) begin
          lo <= data;
        end
      end
      if (ctrl.div_start) begin
        num  <= sum - SUM_W'(hi) - SUM_W'(lo);
        busy <= 1'b1;
      end else if (busy) begin
        // scaled reciprocal product, quotient taken from the upper bits
        quot <= prod[SHIFT +: SAMPLE_W];
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ----- rtl/trimmed_mean_adc_filter_top.sv -----
// top level: sequencer, sample store and shared sum/divide unit
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Trimmed mean filter over a circular store of DEPTH scans of CHANNELS samples.
// After reset the store is cleared one entry per cycle, all CHANNELS*DEPTH
// entries, before the first item is taken. A store item is written as it is
// accepted. Each channel read walks its DEPTH samples through the single read
// port of the store, then divides by DEPTH-2 with one reciprocal multiply; a
// read-all item does this for every channel in turn. An out-of-range channel
// answers without a read. The input is not ready while an item is being worked
// on; a finished result sits in an output register.
module trimmed_mean_adc_filter_top #(
  parameter int CHANNELS = tmaf_pkg::CHANNELS_DEF,
  parameter int DEPTH    = tmaf_pkg::DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  tmaf_req_if.sink          req,
  tmaf_rsp_if.source        rsp
);
  import tmaf_pkg::*;

  localparam int WORDS  = CHANNELS * DEPTH;
  localparam int ADDR_W = $clog2(WORDS);
  localparam int CNT_W  = $clog2(DEPTH);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(WORDS - 1);
  localparam logic [ADDR_W-1:0] STRIDE    = ADDR_W'(CHANNELS);
  localparam logic [CNT_W-1:0]  LAST_CNT  = CNT_W'(DEPTH - 1);
  localparam logic [CH_W-1:0]   LAST_CH   = CH_W'(CHANNELS - 1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_READ, S_DRAIN, S_START, S_DIV, S_EMIT
  } state_t;

  state_t              state;
  logic [ADDR_W-1:0]   clr_addr;
  logic [ADDR_W-1:0]   write_slot;
  logic [ADDR_W-1:0]   rd_addr;
  logic [CNT_W-1:0]    rd_cnt;
  logic                rd_valid;
  logic [CH_W-1:0]     cur_ch;
  logic                all_mode;
  logic                res_ok;
  logic                out_valid;
  logic [CH_W-1:0]     out_ch;
  logic [SAMPLE_W-1:0] out_val;
  logic                out_ok;
  logic                out_last;

  logic                accept;
  logic                emit_go;
  logic                ch_in_range;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [SAMPLE_W-1:0] mem_wdata;
  logic [SAMPLE_W-1:0] mem_rdata;
  logic [SAMPLE_W-1:0] quot;
  calc_ctrl_t          ctrl;
  calc_stat_t          stat;

  assign req.ready   = (state == S_IDLE);
  assign accept      = req.valid && req.ready;
  assign emit_go     = (state == S_EMIT) && (!out_valid || rsp.ready);
  assign ch_in_range = {1'b0, req.channel} < (CH_W + 1)'(CHANNELS);

  // store commands write the next slot; the clearing pass uses the same port
  assign mem_we    = (state == S_CLEAR) || (accept && req.command == CMD_STORE);
  assign mem_waddr = (state == S_CLEAR) ? clr_addr : write_slot;
  assign mem_wdata = (state == S_CLEAR) ? '0 : req.sample;

  assign ctrl.clear     = (state == S_READ) && (rd_cnt == '0);
  assign ctrl.take      = rd_valid;
  assign ctrl.div_start = (state == S_START);

  tmaf_mem #(
    .WORDS (WORDS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (state == S_READ),
    .raddr (rd_addr),
    .rdata (mem_rdata)
  );

  tmaf_calc #(
    .DEPTH (DEPTH)
  ) u_calc (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctrl),
    .data (mem_rdata),
    .stat (stat),
    .quot (quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      write_slot <= '0;
      rd_valid   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      rd_valid <= (state == S_READ);
      if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST_ADDR) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            case (req.command)
              CMD_STORE: begin
                write_slot <= (write_slot == LAST_ADDR) ? '0 : write_slot + 1'b1;
              end
              CMD_READ_ONE: begin
                cur_ch   <= req.channel;
                all_mode <= 1'b0;
                rd_cnt   <= '0;
                if (ch_in_range) begin
                  res_ok  <= 1'b1;
                  rd_addr <= ADDR_W'(req.channel);
                  state   <= S_READ;
                end else begin
                  res_ok <= 1'b0;
                  state  <= S_EMIT;
                end
              end
              CMD_READ_ALL: begin
                cur_ch   <= '0;
                all_mode <= 1'b1;
                res_ok   <= 1'b1;
                rd_cnt   <= '0;
                rd_addr  <= '0;
                state    <= S_READ;
              end
              default: begin
                // unused command: dropped
              end
            endcase
          end
        end
        S_READ: begin
          rd_addr <= rd_addr + STRIDE;
          rd_cnt  <= rd_cnt + 1'b1;
          if (rd_cnt == LAST_CNT) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_START;
        end
        S_START: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (stat.done) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            out_valid <= 1'b1;
            out_ch    <= cur_ch;
            out_val   <= res_ok ? quot : '0;
            out_ok    <= res_ok;
            out_last  <= !all_mode || (cur_ch == LAST_CH);
            if (all_mode && cur_ch != LAST_CH) begin
              cur_ch  <= cur_ch + 1'b1;
              rd_addr <= ADDR_W'(cur_ch + 1'b1);
              rd_cnt  <= '0;
              state   <= S_READ;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.channel_index  = out_ch;
  assign rsp.filtered_value = out_val;
  assign rsp.channel_ok     = out_ok;
  assign rsp.last           = out_last;

  `CHK_IMPLIES(a_div_in_div_state, clk, rst, stat.busy || stat.done, state == S_DIV)
  `CHK_IMPLIES(a_slot_in_range, clk, rst, 1'b1, write_slot <= LAST_ADDR)
  `CHK_NEXT(a_emit_loads_result, clk, rst, emit_go, out_valid)
  `CHK_IMPLIES(a_no_read_while_idle, clk, rst, req.ready, !stat.busy && !rd_valid)

endmodule
